>>> src/b40_pkg.sv
// Shared constants and types for the base-40 code string encoder.
`timescale 1ns / 1ps

package b40_pkg;

   localparam int unsigned B40_LATENCY = 10;

   localparam logic [31:0] B40_LIMIT1   = 32'hF424_0000;
   localparam logic [31:0] B40_LIMIT2   = 32'hFA3E_8000;
   localparam logic [31:0] B40_DEMO_NVK = 32'h5191_75B7;
   localparam logic [31:0] B40_DEMO_RDO = 32'h5191_7645;
   localparam logic [31:0] B40_DEMO_PRF = 32'h5191_7603;
   localparam logic [31:0] B40_DEMO_MST = 32'h5191_758C;

   localparam logic [6:0] CHAR_BANG  = 7'h21;
   localparam logic [6:0] CHAR_HASH  = 7'h23;
   localparam logic [6:0] CHAR_AMP   = 7'h26;
   localparam logic [6:0] CHAR_PLUS  = 7'h2B;
   localparam logic [6:0] CHAR_MINUS = 7'h2D;
   localparam logic [6:0] CHAR_ZERO  = 7'h30;
   localparam logic [6:0] CHAR_UPPER_A = 7'h41;
   localparam logic [6:0] CHAR_UNDER = 7'h5F;
   localparam logic [6:0] CHAR_D     = 7'h44;
   localparam logic [6:0] CHAR_E     = 7'h45;
   localparam logic [6:0] CHAR_M     = 7'h4D;
   localparam logic [6:0] CHAR_O     = 7'h4F;

   // Last three letters of each demo name, in demo index order
   localparam logic [6:0] DEMO_SUFFIX [4][3] = '{
      '{7'h4E, 7'h56, 7'h4B},   // NVK
      '{7'h52, 7'h44, 7'h4F},   // RDO
      '{7'h50, 7'h52, 7'h46},   // PRF
      '{7'h4D, 7'h53, 7'h54}    // MST
   };

   typedef enum logic [1:0] {
      DEMO_NVK = 2'd0,
      DEMO_RDO = 2'd1,
      DEMO_PRF = 2'd2,
      DEMO_MST = 2'd3
   } demo_idx_type;

   typedef struct packed {
      logic         vld;
      logic         demo_hit;
      demo_idx_type demo_idx;
      logic         over1;
      logic         over2;
   } ctl_type;

endpackage

>>> src/b40_split3.sv
// Pipelined split of a value below 68000 into three base-40 digits.
`timescale 1ns / 1ps

module b40_split3 (
   input  logic        clock,
   input  logic [16:0] x,
   output logic [5:0]  dig_hi,
   output logic [5:0]  dig_mid,
   output logic [5:0]  dig_lo
);
   import b40_pkg::*;

   logic [21:0] prod_a;
   logic [5:0]  a_in;
   logic [5:0]  a_ff;
   logic [16:0] xa_ff;

   logic [16:0] prod_b;
   logic [16:0] diff_b;
   logic [10:0] t_in;
   logic [10:0] tb_ff;
   logic [5:0]  ab_ff;

   logic [17:0] prod_c;
   logic [5:0]  b_in;
   logic [5:0]  bc_ff;
   logic [10:0] tc_ff;
   logic [5:0]  ac_ff;

   logic [10:0] prod_d;
   logic [10:0] diff_d;
   logic [5:0]  c_in;
   logic [5:0]  dig_hi_ff;
   logic [5:0]  dig_mid_ff;
   logic [5:0]  dig_lo_ff;

   // x / 1600 = (x >> 6) / 25, reciprocal 1311 / 2^15 exact below 4681
   assign prod_a = {11'd0, x[16:6]} * 22'd1311;
   assign a_in   = prod_a[20:15];

   assign prod_b = {11'd0, a_ff} * 17'd1600;
   assign diff_b = xa_ff - prod_b;
   assign t_in   = diff_b[10:0];

   // t / 40 = (t >> 3) / 5, reciprocal 205 / 2^10 exact below 1024
   assign prod_c = {10'd0, tb_ff[10:3]} * 18'd205;
   assign b_in   = prod_c[15:10];

   assign prod_d = {5'd0, bc_ff} * 11'd40;
   assign diff_d = tc_ff - prod_d;
   assign c_in   = diff_d[5:0];

   always_ff @(posedge clock) begin
      a_ff       <= a_in;
      xa_ff      <= x;
      tb_ff      <= t_in;
      ab_ff      <= a_ff;
      bc_ff      <= b_in;
      tc_ff      <= tb_ff;
      ac_ff      <= ab_ff;
      dig_hi_ff  <= ac_ff;
      dig_mid_ff <= bc_ff;
      dig_lo_ff  <= c_in;
   end

   assign dig_hi  = dig_hi_ff;
   assign dig_mid = dig_mid_ff;
   assign dig_lo  = dig_lo_ff;

endmodule

>>> src/base40_code_string_encoder.sv
// Top level of the base-40 code string encoder.
`timescale 1ns / 1ps
//
// Channel   | Ports                                 | Transfer
// ----------+---------------------------------------+-------------------------------
// request   | start, busy, req_code                 | start high while busy low
// response  | rsp_strobe, rsp_text_char_0..5,       | one cycle with rsp_strobe high
//           | rsp_check_char, rsp_fixed_name_used   |
//
// One code may be taken every cycle; busy stays low. Responses leave in request order.
// The pipeline holds, in order: input register, reciprocal divide by 64000, remainder,
// a four-stage digit split, character map, check sum and the response register.
// Synchronous reset empties the pipeline. The receiver cannot stall, so no response is
// ever held back.

module base40_code_string_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_code,
   output logic        rsp_strobe,
   output logic [6:0]  rsp_text_char_0,
   output logic [6:0]  rsp_text_char_1,
   output logic [6:0]  rsp_text_char_2,
   output logic [6:0]  rsp_text_char_3,
   output logic [6:0]  rsp_text_char_4,
   output logic [6:0]  rsp_text_char_5,
   output logic [6:0]  rsp_check_char,
   output logic        rsp_fixed_name_used
);
   import b40_pkg::*;

   localparam int CTL_DEPTH = 7;

   function automatic logic [6:0] digit_char(input logic [5:0] d);
      logic [5:0] w;
      logic [6:0] c;
      w = (d >= 6'd40) ? d - 6'd40 : d;
      priority if (w <= 6'd9)  c = CHAR_ZERO + {1'b0, w};
      else if (w <= 6'd35)     c = CHAR_UPPER_A + {1'b0, w} - 7'd10;
      else if (w == 6'd36)     c = CHAR_PLUS;
      else if (w == 6'd37)     c = CHAR_MINUS;
      else if (w == 6'd38)     c = CHAR_AMP;
      else                     c = CHAR_UNDER;
      return c;
   endfunction

   function automatic logic [5:0] mod40(input logic [7:0] v);
      logic [7:0] r;
      r = v;
      if (r >= 8'd160) r = r - 8'd160;
      if (r >= 8'd80)  r = r - 8'd80;
      if (r >= 8'd40)  r = r - 8'd40;
      return r[5:0];
   endfunction

   logic        vld0_ff;
   logic [31:0] code0_ff;
   logic        vld1_ff;
   logic [31:0] code1_ff;
   logic [46:0] prod_q;
   logic [16:0] q_in;
   logic [16:0] q1_ff;

   logic [31:0] prod_lo;
   logic [31:0] diff_lo;
   logic [16:0] hi_ff;
   logic [16:0] lo_ff;
   ctl_type     ctl_in;
   ctl_type     ctl_ff [CTL_DEPTH];

   logic [5:0]  dig [6];
   logic [6:0]  char_in [6];
   logic [6:0]  char_ff [6];
   logic [6:0]  word_ff [6];
   logic [7:0]  sum_in;
   logic [7:0]  sum_ff;

   logic [6:0]  chk_char;
   logic [6:0]  out_char_in [6];
   logic [6:0]  out_check_in;
   logic [6:0]  out_char_ff [6];
   logic [6:0]  out_check_ff;
   logic        out_demo_ff;
   logic        out_strobe_ff;

   // code / 64000 = (code >> 9) / 125, reciprocal 8589935 / 2^30
   assign prod_q = {24'd0, code0_ff[31:9]} * 47'd8589935;
   assign q_in   = prod_q[46:30];

   assign prod_lo = {15'd0, q1_ff} * 32'd64000;
   assign diff_lo = code1_ff - prod_lo;

   always_comb begin
      ctl_in          = '0;
      ctl_in.vld      = vld1_ff;
      ctl_in.over1    = (code1_ff >= B40_LIMIT1);
      ctl_in.over2    = (code1_ff >= B40_LIMIT2);
      ctl_in.demo_hit = 1'b1;
      priority if (code1_ff == B40_DEMO_NVK) ctl_in.demo_idx = DEMO_NVK;
      else if (code1_ff == B40_DEMO_RDO)     ctl_in.demo_idx = DEMO_RDO;
      else if (code1_ff == B40_DEMO_PRF)     ctl_in.demo_idx = DEMO_PRF;
      else if (code1_ff == B40_DEMO_MST)     ctl_in.demo_idx = DEMO_MST;
      else                                   ctl_in.demo_hit = 1'b0;
   end

   always_ff @(posedge clock) begin
      code0_ff <= req_code;
      q1_ff    <= q_in;
      code1_ff <= code0_ff;
      hi_ff    <= q1_ff;
      lo_ff    <= {1'b0, diff_lo[15:0]};
      if (reset) begin
         vld0_ff <= 1'b0;
         vld1_ff <= 1'b0;
         for (int i = 0; i < CTL_DEPTH; i++) ctl_ff[i] <= '0;
      end else begin
         vld0_ff   <= start && !busy;
         vld1_ff   <= vld0_ff;
         ctl_ff[0] <= ctl_in;
         for (int i = 1; i < CTL_DEPTH; i++) ctl_ff[i] <= ctl_ff[i-1];
      end
   end

   b40_split3 u_split_hi (
      .clock   (clock),
      .x       (hi_ff),
      .dig_hi  (dig[0]),
      .dig_mid (dig[1]),
      .dig_lo  (dig[2])
   );

   b40_split3 u_split_lo (
      .clock   (clock),
      .x       (lo_ff),
      .dig_hi  (dig[3]),
      .dig_mid (dig[4]),
      .dig_lo  (dig[5])
   );

   always_comb begin
      for (int i = 0; i < 6; i++) char_in[i] = digit_char(dig[i]);
   end

   // Check sum: start at 0xFF, rotate left by two, add each character
   always_comb begin
      logic [7:0] s;
      s = 8'hFF;
      for (int i = 0; i < 6; i++) s = {s[5:0], s[7:6]} + {1'b0, char_ff[i]};
      sum_in = s;
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      word_ff <= char_ff;
      sum_ff  <= sum_in;
   end

   assign chk_char = digit_char(mod40(sum_ff));

   always_comb begin
      out_char_in  = word_ff;
      out_check_in = chk_char;
      if (ctl_ff[6].over2) begin
         out_char_in[0] = CHAR_HASH;
      end else if (ctl_ff[6].over1) begin
         out_char_in[0] = CHAR_BANG;
      end
      if (ctl_ff[6].demo_hit) begin
         out_char_in[0] = CHAR_D;
         out_char_in[1] = CHAR_E;
         out_char_in[2] = CHAR_M;
         out_char_in[3] = CHAR_O;
         out_char_in[4] = DEMO_SUFFIX[ctl_ff[6].demo_idx][0];
         out_char_in[5] = DEMO_SUFFIX[ctl_ff[6].demo_idx][1];
         out_check_in   = DEMO_SUFFIX[ctl_ff[6].demo_idx][2];
      end
   end

   always_ff @(posedge clock) begin
      out_char_ff  <= out_char_in;
      out_check_ff <= out_check_in;
      out_demo_ff  <= ctl_ff[6].demo_hit;
      if (reset) begin
         out_strobe_ff <= 1'b0;
      end else begin
         out_strobe_ff <= ctl_ff[6].vld;
      end
   end

   assign busy                = 1'b0;
   assign rsp_strobe          = out_strobe_ff;
   assign rsp_text_char_0     = out_char_ff[0];
   assign rsp_text_char_1     = out_char_ff[1];
   assign rsp_text_char_2     = out_char_ff[2];
   assign rsp_text_char_3     = out_char_ff[3];
   assign rsp_text_char_4     = out_char_ff[4];
   assign rsp_text_char_5     = out_char_ff[5];
   assign rsp_check_char      = out_check_ff;
   assign rsp_fixed_name_used = out_demo_ff;

endmodule

>>> src/b40_checker.sv
// Port-level checks for the base-40 code string encoder, bound to the top level.
`timescale 1ns / 1ps

module b40_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [31:0] req_code,
   input logic        rsp_strobe,
   input logic [6:0]  rsp_text_char_0,
   input logic [6:0]  rsp_check_char,
   input logic        rsp_fixed_name_used
);
   import b40_pkg::*;

   // every transfer yields exactly one response, a fixed number of cycles later
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##B40_LATENCY rsp_strobe)
      else $error("request transfer not answered on time");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy && !reset, B40_LATENCY))
      else $error("response without a matching request");

   a_demo_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(req_code, B40_LATENCY) == B40_DEMO_NVK)
         |-> (rsp_fixed_name_used && rsp_text_char_0 == CHAR_D
              && rsp_check_char == DEMO_SUFFIX[DEMO_NVK][2]))
      else $error("demo code not rendered as its name");

   a_prefix: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(req_code, B40_LATENCY) >= B40_LIMIT1)
         |-> (rsp_text_char_0 == CHAR_BANG || rsp_text_char_0 == CHAR_HASH))
      else $error("large code lacks its prefix");

endmodule

bind base40_code_string_encoder b40_checker u_b40_checker (.*);

>>> dv/testbench.sv
// Self-checking testbench for the base-40 code string encoder.
`timescale 1ns / 1ps

module testbench;
   import b40_pkg::*;

   localparam logic [31:0] DEMO_CODES [4] = '{B40_DEMO_NVK, B40_DEMO_RDO,
                                             B40_DEMO_PRF, B40_DEMO_MST};
   localparam logic [55:0] DEMO_NAMES [4] = '{"DEMONVK", "DEMORDO",
                                             "DEMOPRF", "DEMOMST"};
   localparam int unsigned RANDOM_CODES = 1000;
   localparam int unsigned QUIET_TAIL   = 150;

   typedef struct {
      logic [31:0] code;
      logic [6:0]  chr [6];
      logic [6:0]  check;
      logic        fixed;
   } b40_text_type;

   class b40_text_scoreboard;
      b40_text_type pending_texts [$];
      int           errors;

      function logic [6:0] digit_to_char(int unsigned d);
         if (d <= 9)       return CHAR_ZERO + 7'(d);
         else if (d < 36)  return CHAR_UPPER_A + 7'(d - 10);
         else if (d == 36) return CHAR_PLUS;
         else if (d == 37) return CHAR_MINUS;
         else if (d == 38) return CHAR_AMP;
         else              return CHAR_UNDER;
      endfunction

      function b40_text_type encode_code(logic [31:0] code);
         b40_text_type t;
         int           demo;
         logic [31:0]  v;
         logic [7:0]   sum;
         demo = -1;
         t.code = code;
         for (int k = 0; k < 4; k++)
            if (code == DEMO_CODES[k]) demo = k;
         if (demo >= 0) begin
            for (int k = 0; k < 6; k++)
               t.chr[k] = DEMO_NAMES[demo][8*(6-k) +: 7];
            t.check = DEMO_NAMES[demo][6:0];
            t.fixed = 1'b1;
         end else begin
            v = code;
            for (int k = 5; k >= 0; k--) begin
               t.chr[k] = digit_to_char(v % 40);
               v = v / 40;
            end
            sum = 8'hFF;
            for (int k = 0; k < 6; k++)
               sum = {sum[5:0], sum[7:6]} + {1'b0, t.chr[k]};
            t.check = digit_to_char(sum % 40);
            // prefix overwrites the top digit only after the check is formed
            if (code >= B40_LIMIT2)
               t.chr[0] = CHAR_HASH;
            else if (code >= B40_LIMIT1)
               t.chr[0] = CHAR_BANG;
            t.fixed = 1'b0;
         end
         return t;
      endfunction

      function void note_code(logic [31:0] code);
         pending_texts.push_back(encode_code(code));
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= 10) $display("error: %s", msg);
      endfunction

      function void check_result(b40_text_type got);
         b40_text_type want;
         bit           bad;
         if (pending_texts.size() == 0) begin
            report("response with no request outstanding");
            return;
         end
         want = pending_texts.pop_front();
         bad = (got.check !== want.check) || (got.fixed !== want.fixed);
         for (int k = 0; k < 6; k++)
            if (got.chr[k] !== want.chr[k]) bad = 1'b1;
         if (bad)
            report($sformatf({"code %h: expected %c%c%c%c%c%c%c fixed=%b, ",
                              "got %c%c%c%c%c%c%c fixed=%b"}, want.code,
                             want.chr[0], want.chr[1], want.chr[2], want.chr[3],
                             want.chr[4], want.chr[5], want.check, want.fixed,
                             got.chr[0], got.chr[1], got.chr[2], got.chr[3],
                             got.chr[4], got.chr[5], got.check, got.fixed));
      endfunction

      function int outstanding();
         return pending_texts.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_code;
   logic        rsp_strobe;
   logic [6:0]  rsp_text_char_0;
   logic [6:0]  rsp_text_char_1;
   logic [6:0]  rsp_text_char_2;
   logic [6:0]  rsp_text_char_3;
   logic [6:0]  rsp_text_char_4;
   logic [6:0]  rsp_text_char_5;
   logic [6:0]  rsp_check_char;
   logic        rsp_fixed_name_used;

   b40_text_scoreboard sb = new();

   base40_code_string_encoder dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_code            (req_code),
      .rsp_strobe          (rsp_strobe),
      .rsp_text_char_0     (rsp_text_char_0),
      .rsp_text_char_1     (rsp_text_char_1),
      .rsp_text_char_2     (rsp_text_char_2),
      .rsp_text_char_3     (rsp_text_char_3),
      .rsp_text_char_4     (rsp_text_char_4),
      .rsp_text_char_5     (rsp_text_char_5),
      .rsp_check_char      (rsp_check_char),
      .rsp_fixed_name_used (rsp_fixed_name_used)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   always @(posedge clock) begin
      b40_text_type got;
      if (!reset && rsp_strobe) begin
         got.code   = 'x;
         got.chr[0] = rsp_text_char_0;
         got.chr[1] = rsp_text_char_1;
         got.chr[2] = rsp_text_char_2;
         got.chr[3] = rsp_text_char_3;
         got.chr[4] = rsp_text_char_4;
         got.chr[5] = rsp_text_char_5;
         got.check  = rsp_check_char;
         got.fixed  = rsp_fixed_name_used;
         sb.check_result(got);
      end
   end

   // One transfer; an optional idle burst first. Returns on the accepting edge.
   task automatic send_code(input logic [31:0] code, input bit may_idle);
      int gap;
      if (may_idle && $urandom_range(4) == 0) begin
         gap = $urandom_range(9, 1);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_code <= code;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_code(code);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   initial begin
      logic [31:0] directed [$];
      logic [31:0] code;
      logic [31:0] edge_val;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_code <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed = '{32'h0000_0000, 32'hFFFF_FFFF, 32'd1, 32'd39, 32'd40,
                   32'h061A_7FFF, 32'h061A_8000,
                   B40_DEMO_NVK, B40_DEMO_RDO, B40_DEMO_PRF, B40_DEMO_MST,
                   B40_DEMO_NVK + 32'd1, B40_DEMO_MST - 32'd1,
                   B40_LIMIT1 - 32'd1, B40_LIMIT1, B40_LIMIT2 - 32'd1, B40_LIMIT2,
                   32'd3783614835,   // digits 36..39 present
                   32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'h8000_0000};
      foreach (directed[k]) send_code(directed[k], 1'b1);
      drain();

      for (int n = 0; n < RANDOM_CODES; n++) begin
         case ($urandom_range(9))
            0, 1, 2, 3: code = $urandom();
            4:          code = DEMO_CODES[$urandom_range(3)] + 32'($urandom_range(4)) - 32'd2;
            5, 6:       code = $urandom_range(32'hFFFF_FFFF, B40_LIMIT1);
            7:          code = $urandom_range(32'd200_000);
            default: begin
               case ($urandom_range(3))
                  0:       edge_val = B40_LIMIT1;
                  1:       edge_val = B40_LIMIT2;
                  2:       edge_val = 32'h061A_8000;
                  default: edge_val = 32'h0000_0000;
               endcase
               code = edge_val + 32'($urandom_range(32)) - 32'd16;
            end
         endcase
         send_code(code, n < RANDOM_CODES - QUIET_TAIL);
         // let the pipeline run dry once mid-run
         if (n == RANDOM_CODES / 2) drain();
      end

      drain();
      repeat (B40_LATENCY + 5) @(posedge clock);
      if (sb.outstanding() != 0) sb.report("responses missing at end of run");
      if (sb.errors == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

>>> files.f
src/b40_pkg.sv
src/b40_split3.sv
src/base40_code_string_encoder.sv
src/b40_checker.sv
dv/testbench.sv
